// ===== rtl/mkbrs_pkg.sv =====
// mkbrs_pkg: shared types, constants and helpers for the multi-key bitonic row sorter
// no dependencies
package mkbrs_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int NUM_FIELDS  = 4;
  localparam int FIELD_WIDTH = 32;
  localparam int KEY_SLOTS   = 4;
  localparam int ROW_AW      = $clog2(MAX_ROWS);
  localparam int CNT_W       = ROW_AW + 1;
  localparam int FIELD_IW    = $clog2(NUM_FIELDS);
  localparam int KEY_W       = 3 * KEY_SLOTS;
  localparam int DATA_W      = NUM_FIELDS * FIELD_WIDTH;
  localparam int CFG_IW      = 2;
  localparam int STACK_DEPTH = 2 * ROW_AW + 4;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);

  // register indexes
  localparam logic [CFG_IW-1:0] REG_ASCENDING       = 2'd0;
  localparam logic [CFG_IW-1:0] REG_DUMMY_ASCENDING = 2'd1;
  localparam logic [CFG_IW-1:0] REG_KEY_ORDER       = 2'd2;

  // key slot codes
  localparam logic [2:0] SLOT_DUMMY = 3'd4;
  localparam logic [2:0] SLOT_END   = 3'd7;

  localparam logic [KEY_W-1:0] KEY_ORDER_RESET = KEY_W'(4088);

  // recursion frame kinds and phases
  localparam logic KIND_SORT  = 1'b0;
  localparam logic KIND_MERGE = 1'b1;
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  typedef struct packed {
    logic                            dummy;
    logic [NUM_FIELDS-1:0][FIELD_WIDTH-1:0] fields;
  } row_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        phase;
    logic [ROW_AW-1:0] lo;
    logic [CNT_W-1:0]  n;
    logic              flip;
  } frame_t;

  // controller to datapath
  typedef struct packed {
    logic              load_we;
    logic              cnt_clr;
    logic              rd_en;
    logic              cmp_en;
    logic              wr_i;
    logic              wr_j;
    logic              flip;
    logic [ROW_AW-1:0] addr_i;
    logic [ROW_AW-1:0] addr_j;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
  } stat_t;

  // largest power of two strictly below n, for n of two or more
  function automatic logic [CNT_W-1:0] pow2_below(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] nm1;
    logic [CNT_W-1:0] m;
    nm1 = n - 1'b1;
    m = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (nm1[b]) m = CNT_W'(1) << b;
    end
    return m;
  endfunction

endpackage

// ===== rtl/mkbrs_datapath.sv =====
// mkbrs_datapath: row memory, row count, configuration registers and row compare unit
// depends on mkbrs_pkg
module mkbrs_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  mkbrs_pkg::cmd_t              cmd,
  output mkbrs_pkg::stat_t             stat,
  input  logic [mkbrs_pkg::DATA_W-1:0] s_tdata,
  input  logic                         s_tuser,
  input  logic                         cfg_we,
  input  logic [mkbrs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mkbrs_pkg::KEY_W-1:0]  cfg_data,
  output logic [mkbrs_pkg::DATA_W-1:0] m_tdata,
  output logic                         m_tuser
);

  mkbrs_pkg::row_t mem [mkbrs_pkg::MAX_ROWS];
  mkbrs_pkg::row_t row_a;
  mkbrs_pkg::row_t row_b;
  mkbrs_pkg::row_t wr_row;
  logic [mkbrs_pkg::ROW_AW-1:0] wr_addr;
  logic                         wr_en;
  logic [mkbrs_pkg::CNT_W-1:0]  cnt;
  logic                         ascending;
  logic                         dummy_ascending;
  logic [mkbrs_pkg::KEY_W-1:0]  key_order;
  logic                         swap;
  logic                         swap_next;

  assign stat.cnt = cnt;
  assign m_tdata  = row_a.fields;
  assign m_tuser  = row_a.dummy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ascending       <= 1'b1;
      dummy_ascending <= 1'b1;
      key_order       <= mkbrs_pkg::KEY_ORDER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mkbrs_pkg::REG_ASCENDING:       ascending <= cfg_data[0];
        mkbrs_pkg::REG_DUMMY_ASCENDING: dummy_ascending <= cfg_data[0];
        mkbrs_pkg::REG_KEY_ORDER:       key_order <= cfg_data;
        default: ;
      endcase
    end
  end

  // row count
  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.load_we && cnt < mkbrs_pkg::CNT_W'(mkbrs_pkg::MAX_ROWS)) begin
      cnt <= cnt + 1'b1;
    end
  end

  // single write port: load, or write back of a compared pair
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmd.addr_i;
    wr_row  = swap ? row_b : row_a;
    if (cmd.load_we) begin
      wr_en        = cnt < mkbrs_pkg::CNT_W'(mkbrs_pkg::MAX_ROWS);
      wr_addr      = cnt[mkbrs_pkg::ROW_AW-1:0];
      wr_row.fields = s_tdata;
      wr_row.dummy  = s_tuser;
    end else if (cmd.wr_i) begin
      wr_en = 1'b1;
    end else if (cmd.wr_j) begin
      wr_en   = 1'b1;
      wr_addr = cmd.addr_j;
      wr_row  = swap ? row_a : row_b;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
  end

  // registered reads of the pair, port a doubles as the output register
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      row_a <= mem[cmd.addr_i];
      row_b <= mem[cmd.addr_j];
    end
  end

  // lexicographic compare over the key slots, equality prefix accumulates
  always_comb begin
    logic [2:0] code;
    logic       run;
    logic       pe;
    logic       use_slot;
    logic       gt;
    logic       lt;
    logic       eq;
    logic       d;
    run = 1'b1;
    pe = 1'b1;
    swap_next = 1'b0;
    for (int s = 0; s < mkbrs_pkg::KEY_SLOTS; s++) begin
      code = key_order[3*s +: 3];
      if (code == mkbrs_pkg::SLOT_END) run = 1'b0;
      if (code == mkbrs_pkg::SLOT_DUMMY) begin
        use_slot = run;
        gt = row_a.dummy & ~row_b.dummy;
        lt = ~row_a.dummy & row_b.dummy;
        eq = row_a.dummy == row_b.dummy;
        d  = dummy_ascending ^ cmd.flip;
      end else begin
        use_slot = run && !code[2] && int'(code) < mkbrs_pkg::NUM_FIELDS;
        gt = $signed(row_a.fields[code[mkbrs_pkg::FIELD_IW-1:0]])
             > $signed(row_b.fields[code[mkbrs_pkg::FIELD_IW-1:0]]);
        lt = $signed(row_a.fields[code[mkbrs_pkg::FIELD_IW-1:0]])
             < $signed(row_b.fields[code[mkbrs_pkg::FIELD_IW-1:0]]);
        eq = row_a.fields[code[mkbrs_pkg::FIELD_IW-1:0]]
             == row_b.fields[code[mkbrs_pkg::FIELD_IW-1:0]];
        d  = ascending ^ cmd.flip;
      end
      if (use_slot) begin
        if (pe && (d ? gt : lt)) swap_next = 1'b1;
        pe = pe & eq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) swap <= swap_next;
  end

endmodule

// ===== rtl/mkbrs_ctrl.sv =====
// mkbrs_ctrl: sequencer for load, recursive bitonic sort with a frame stack, and output
// depends on mkbrs_pkg
module mkbrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  output logic              m_tvalid,
  output logic              m_tlast,
  input  logic              m_tready,
  output mkbrs_pkg::cmd_t   cmd,
  input  mkbrs_pkg::stat_t  stat
);

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_STEP, S_RD, S_CMP, S_WI, S_WJ, S_OUT_RD, S_OUT_SEND
  } state_t;

  state_t state;
  mkbrs_pkg::frame_t top;
  mkbrs_pkg::frame_t stack [mkbrs_pkg::STACK_DEPTH];
  logic [mkbrs_pkg::STACK_AW:0]   sp;
  logic [mkbrs_pkg::STACK_AW:0]   sp_m1;
  logic [mkbrs_pkg::ROW_AW-1:0]   idx;
  logic [mkbrs_pkg::CNT_W-1:0]    m;
  logic [mkbrs_pkg::CNT_W-1:0]    h;
  logic [mkbrs_pkg::CNT_W-1:0]    pairs;
  logic                           is_last;

  assign m       = mkbrs_pkg::pow2_below(top.n);
  assign h       = top.n >> 1;
  assign pairs   = top.n - m;
  assign sp_m1   = sp - 1'b1;
  assign is_last = ({1'b0, idx} + 1'b1) == stat.cnt;

  assign s_tready = state == S_LOAD;
  assign m_tvalid = state == S_OUT_SEND;
  assign m_tlast  = is_last;

  // commands to the datapath
  always_comb begin
    cmd = '0;
    cmd.flip    = top.flip;
    cmd.load_we = s_tvalid && state == S_LOAD;
    cmd.rd_en   = state == S_RD || state == S_OUT_RD;
    cmd.cmp_en  = state == S_CMP;
    cmd.wr_i    = state == S_WI;
    cmd.wr_j    = state == S_WJ;
    cmd.cnt_clr = state == S_OUT_SEND && m_tready && is_last;
    if (state == S_OUT_RD) begin
      cmd.addr_i = idx;
      cmd.addr_j = idx;
    end else begin
      cmd.addr_i = top.lo + idx;
      cmd.addr_j = top.lo + idx + m[mkbrs_pkg::ROW_AW-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      sp    <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (s_tvalid && s_tlast) state <= S_INIT;
        end
        S_INIT: begin
          top   <= '{kind: mkbrs_pkg::KIND_SORT, phase: mkbrs_pkg::PH_FIRST,
                     lo: '0, n: stat.cnt, flip: 1'b0};
          sp    <= '0;
          state <= S_STEP;
        end
        S_STEP: begin
          if (top.phase == mkbrs_pkg::PH_FIRST && top.n <= mkbrs_pkg::CNT_W'(1)) begin
            // frame done: pop, or finish when the stack is empty
            if (sp == '0) begin
              idx   <= '0;
              state <= S_OUT_RD;
            end else begin
              top <= stack[sp_m1[mkbrs_pkg::STACK_AW-1:0]];
              sp  <= sp_m1;
            end
          end else if (top.kind == mkbrs_pkg::KIND_SORT) begin
            unique case (top.phase)
              mkbrs_pkg::PH_FIRST: begin
                stack[sp[mkbrs_pkg::STACK_AW-1:0]] <= '{kind: top.kind,
                  phase: mkbrs_pkg::PH_SECOND, lo: top.lo, n: top.n, flip: top.flip};
                sp  <= sp + 1'b1;
                top <= '{kind: mkbrs_pkg::KIND_SORT, phase: mkbrs_pkg::PH_FIRST,
                         lo: top.lo, n: h, flip: ~top.flip};
              end
              mkbrs_pkg::PH_SECOND: begin
                stack[sp[mkbrs_pkg::STACK_AW-1:0]] <= '{kind: top.kind,
                  phase: mkbrs_pkg::PH_THIRD, lo: top.lo, n: top.n, flip: top.flip};
                sp  <= sp + 1'b1;
                top <= '{kind: mkbrs_pkg::KIND_SORT, phase: mkbrs_pkg::PH_FIRST,
                         lo: top.lo + h[mkbrs_pkg::ROW_AW-1:0], n: top.n - h,
                         flip: top.flip};
              end
              default: begin
                top <= '{kind: mkbrs_pkg::KIND_MERGE, phase: mkbrs_pkg::PH_FIRST,
                         lo: top.lo, n: top.n, flip: top.flip};
              end
            endcase
          end else begin
            unique case (top.phase)
              mkbrs_pkg::PH_FIRST: begin
                // compare-swap pass over lo+i against lo+i+m
                top.phase <= mkbrs_pkg::PH_SECOND;
                idx       <= '0;
                state     <= S_RD;
              end
              mkbrs_pkg::PH_SECOND: begin
                stack[sp[mkbrs_pkg::STACK_AW-1:0]] <= '{kind: top.kind,
                  phase: mkbrs_pkg::PH_THIRD, lo: top.lo, n: top.n, flip: top.flip};
                sp  <= sp + 1'b1;
                top <= '{kind: mkbrs_pkg::KIND_MERGE, phase: mkbrs_pkg::PH_FIRST,
                         lo: top.lo, n: m, flip: top.flip};
              end
              default: begin
                top <= '{kind: mkbrs_pkg::KIND_MERGE, phase: mkbrs_pkg::PH_FIRST,
                         lo: top.lo + m[mkbrs_pkg::ROW_AW-1:0], n: pairs,
                         flip: top.flip};
              end
            endcase
          end
        end
        S_RD:  state <= S_CMP;
        S_CMP: state <= S_WI;
        S_WI:  state <= S_WJ;
        S_WJ: begin
          if (({1'b0, idx} + 1'b1) == pairs) begin
            state <= S_STEP;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_OUT_RD: state <= S_OUT_SEND;
        S_OUT_SEND: begin
          if (m_tready) begin
            if (is_last) begin
              state <= S_LOAD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // stack stays within its depth
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= (mkbrs_pkg::STACK_AW+1)'(mkbrs_pkg::STACK_DEPTH))
    else $error("frame stack overflow");

  // no input taken while results are offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output active together");

  // a stalled result keeps its row index
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(idx)))
    else $error("output index moved while stalled");

  // the sort starts with at least one row held
  a_init_rows: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> (stat.cnt != '0))
    else $error("sort started with no rows");

endmodule

// ===== rtl/multi_key_bitonic_row_sorter.sv =====
// multi_key_bitonic_row_sorter: top level, joins the sequencer and the row datapath
// depends on mkbrs_pkg, mkbrs_ctrl, mkbrs_datapath
//
// Usage:
//   Rows arrive on the s_ channel, one per cycle while s_tready is high. s_tdata
//   carries the four signed fields, s_tuser the dummy flag, s_tlast closes the set.
//   Rows beyond 64 are dropped; a dropped row with s_tlast still starts the sort.
//   After the last row s_tready falls and the set is sorted in place by a bitonic
//   network for any row count, driven by a frame stack in the sequencer. Each
//   compare-swap works on the row memory (read pair, compare, write two rows
//   through the single write port). 64 rows take 672 compare-swaps and about
//   1600 frame steps. The sorted rows leave on the m_ channel; each row is read
//   into the output register before it is offered, and a stall holds the row
//   there. s_tready rises again after the row with m_tlast is taken.
//   The cfg port writes ascending (0), dummy_ascending (1), key_order (2); the
//   user must write them only while idle, and the block does not enforce this.
//   Reset (rst, synchronous) clears the row count and restores the register defaults;
//   row memory contents are not cleared.
module multi_key_bitonic_row_sorter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [mkbrs_pkg::DATA_W-1:0] s_tdata,  // field0, field1, field2, field3
  input  logic                         s_tuser,  // dummy
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [mkbrs_pkg::DATA_W-1:0] m_tdata,  // out_field0 .. out_field3
  output logic                         m_tuser,  // out_dummy
  output logic                         m_tlast,
  input  logic                         cfg_we,
  input  logic [mkbrs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mkbrs_pkg::KEY_W-1:0]  cfg_data
);

  mkbrs_pkg::cmd_t  cmd;
  mkbrs_pkg::stat_t stat;

  // sequencer
  mkbrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tlast  (m_tlast),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // row storage and compare
  mkbrs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
